// ===== sv/timed_line_locator_with_progress_macros.svh =====
// assertion macros for the timed line locator checker
`ifndef TIMED_LINE_LOCATOR_WITH_PROGRESS_MACROS_SVH
`define TIMED_LINE_LOCATOR_WITH_PROGRESS_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TLLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TLLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tllp_pkg.sv =====
// shared types and constants for the timed line locator
`default_nettype none

package tllp_pkg;

    localparam int TIME_W         = 32;
    localparam int SLOT_W         = 6;
    localparam int IDX_W          = 7;
    localparam int CNT_REG_W      = 7;
    localparam int PROG_FRAC_BITS = 16;
    localparam int PROG_W         = PROG_FRAC_BITS + 1;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_AW       = 1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [IDX_W-1:0]  IDX_NONE  = {IDX_W{1'b1}};
    localparam logic [PROG_W-1:0] PROG_ONE  = PROG_W'(1) << PROG_FRAC_BITS;
    localparam logic [PROG_W-1:0] PROG_ZERO = '0;

    typedef struct packed {
        logic              is_query;
        logic              wr_en;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] start_ms;
        logic [TIME_W-1:0] stop_ms;
        logic [TIME_W-1:0] pos_ms;
    } cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0] start_ms;
        logic [TIME_W-1:0] stop_ms;
    } entry_t;

    typedef struct packed {
        logic signed [IDX_W-1:0] line_index;
        logic [PROG_W-1:0]       progress;
        logic                    index_changed;
        logic                    progress_changed;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK0,
        S_ISSUE,
        S_CMP,
        S_PREP,
        S_SAT,
        S_DIV,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== sv/timed_line_locator_with_progress.sv =====
// query: s = ceil(log2(count+1)) binary search steps, each an issue and a compare state
// on the line table, then prep and saturate states and the 16-bit divider; zero or
// saturated progress skips the divider; empty table or before first line: straight to output
// write beat: written as the back end takes it; one item in the back end at a time, two-entry
// queue in front, registered result at the output
// reset (rst_n, async): control, last index (-1), last progress (0) cleared; table undefined
`default_nettype none

module timed_line_locator_with_progress #(
    parameter int MAX_LINES = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tllp_pkg::CNT_REG_W-1:0]       cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 op,
    input  wire logic [tllp_pkg::SLOT_W-1:0]          entry_index,
    input  wire logic [tllp_pkg::TIME_W-1:0]          entry_start_ms,
    input  wire logic [tllp_pkg::TIME_W-1:0]          entry_end_ms,
    input  wire logic signed [tllp_pkg::TIME_W-1:0]   position_ms,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [tllp_pkg::IDX_W-1:0]         line_index,
    output logic [tllp_pkg::PROG_W-1:0]               progress,
    output logic                                      index_changed,
    output logic                                      progress_changed
);

    logic [tllp_pkg::CNT_REG_W-1:0] line_count_reg;
    logic                           cmd_valid;
    logic                           cmd_ready;
    tllp_pkg::cmd_t                 cmd;
    tllp_pkg::res_t                 res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            line_count_reg <= cfg_data;
        end
    end

    tllp_front #(
        .MAX_LINES (MAX_LINES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .entry_index    (entry_index),
        .entry_start_ms (entry_start_ms),
        .entry_end_ms   (entry_end_ms),
        .position_ms    (position_ms),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd)
    );

    tllp_back #(
        .MAX_LINES (MAX_LINES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .line_count (line_count_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res        (res)
    );

    assign line_index       = res.line_index;
    assign progress         = res.progress;
    assign index_changed    = res.index_changed;
    assign progress_changed = res.progress_changed;

endmodule

`default_nettype wire

// ===== sv/tllp_front.sv =====
// front end: accepts input beats, classifies them and queues them for the back end
`default_nettype none

module tllp_front #(
    parameter int MAX_LINES = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          op,
    input  wire logic [tllp_pkg::SLOT_W-1:0]   entry_index,
    input  wire logic [tllp_pkg::TIME_W-1:0]   entry_start_ms,
    input  wire logic [tllp_pkg::TIME_W-1:0]   entry_end_ms,
    input  wire logic signed [tllp_pkg::TIME_W-1:0] position_ms,
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output tllp_pkg::cmd_t                     cmd
);

    localparam int QCW = tllp_pkg::QUEUE_AW + 1;

    tllp_pkg::cmd_t                  q_reg [tllp_pkg::QUEUE_DEPTH];
    logic [tllp_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [tllp_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]                  cnt_reg;
    logic [QCW-1:0]                  cnt_next;
    tllp_pkg::cmd_t                  new_cmd;
    logic                            push;
    logic                            pop;

    // classify the beat: query or write, slot in range, clamp negative position
    always_comb
    begin
        new_cmd.is_query = (op == tllp_pkg::OP_QUERY);
        new_cmd.wr_en    = (op == tllp_pkg::OP_WRITE) && (int'(entry_index) < MAX_LINES);
        new_cmd.slot     = entry_index;
        new_cmd.start_ms = entry_start_ms;
        new_cmd.stop_ms  = entry_end_ms;
        if (position_ms[tllp_pkg::TIME_W-1])
        begin
            new_cmd.pos_ms = '0;
        end
        else
        begin
            new_cmd.pos_ms = {1'b0, position_ms[tllp_pkg::TIME_W-2:0]};
        end
    end

    assign in_ready  = (cnt_reg != QCW'(tllp_pkg::QUEUE_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + QCW'(1);
            2'b01:   cnt_next = cnt_reg - QCW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + tllp_pkg::QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + tllp_pkg::QUEUE_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tllp_div.sv =====
// restoring divider for the progress fraction, one quotient bit per cycle
`default_nettype none

module tllp_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [tllp_pkg::TIME_W-1:0]         num,
    input  wire logic [tllp_pkg::TIME_W-1:0]         den,
    output logic                                     done,
    output logic [tllp_pkg::PROG_FRAC_BITS-1:0]      quot
);

    localparam int CNT_W = $clog2(tllp_pkg::PROG_FRAC_BITS + 1);
    localparam int TW    = tllp_pkg::TIME_W;
    localparam int QW    = tllp_pkg::PROG_FRAC_BITS;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [TW-1:0]    rem_reg;
    logic [TW-1:0]    den_reg;
    logic [QW-1:0]    quot_reg;
    logic [TW:0]      trial;
    logic [TW:0]      diff;
    logic             ge;

    // remainder stays below the divisor, so the shifted trial fits one extra bit
    assign trial = {rem_reg, 1'b0};
    assign ge    = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};
    assign done  = done_reg;
    assign quot  = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[TW-1:0] : trial[TW-1:0];
            quot_reg <= {quot_reg[QW-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// ===== sv/tllp_back.sv =====
// back end: line table, binary search sequencer, progress divide and result register
`default_nettype none

module tllp_back #(
    parameter int MAX_LINES = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_ready,
    input  wire tllp_pkg::cmd_t                  cmd,
    input  wire logic [tllp_pkg::CNT_REG_W-1:0]  line_count,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output tllp_pkg::res_t                       res
);

    localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int TW = tllp_pkg::TIME_W;
    localparam int PW = tllp_pkg::PROG_W;
    localparam int IW = tllp_pkg::IDX_W;

    tllp_pkg::entry_t lines_mem [MAX_LINES];
    tllp_pkg::entry_t rd_data_reg;

    tllp_pkg::state_t state_reg;
    tllp_pkg::state_t state_next;

    logic [TW-1:0]  pos_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  lo_reg;
    logic [CW-1:0]  hi1_reg;
    logic [AW-1:0]  found_reg;
    logic           found_ok_reg;
    logic [TW-1:0]  fstart_reg;
    logic [TW-1:0]  fstop_reg;
    logic [TW-1:0]  num_reg;
    logic [TW-1:0]  den_reg;
    logic           zero_reg;
    logic [PW-1:0]  prog_reg;
    logic [IW-1:0]  last_idx_reg;
    logic [PW-1:0]  last_prog_reg;
    logic           out_valid_reg;
    tllp_pkg::res_t out_res_reg;

    logic [CW:0]    mid_sum;
    logic [CW-1:0]  mid_full;
    logic [AW-1:0]  mid;
    logic           search_go;
    logic           hit;
    logic           sat;
    logic [CW-1:0]  count_clamp;
    logic [IW-1:0]  idx_now;

    logic           mem_we;
    logic [AW-1:0]  rd_addr;
    logic           div_start;
    logic           div_done;
    logic [tllp_pkg::PROG_FRAC_BITS-1:0] div_quot;
    logic           out_load;
    logic           take_query;

    assign mid_sum     = (CW+1)'(lo_reg) + (CW+1)'(hi1_reg) - (CW+1)'(1);
    assign mid_full    = mid_sum[CW:1];
    assign mid         = mid_full[AW-1:0];
    assign search_go   = (lo_reg < hi1_reg);
    assign hit         = (rd_data_reg.start_ms <= pos_reg);
    assign sat         = (num_reg >= den_reg);
    assign count_clamp = (int'(line_count) > MAX_LINES) ? CW'(MAX_LINES) : CW'(line_count);
    assign idx_now     = found_ok_reg ? IW'(found_reg) : tllp_pkg::IDX_NONE;
    assign take_query  = cmd_valid && cmd.is_query;

    tllp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tllp_pkg::S_IDLE:
            begin
                if (take_query)
                begin
                    state_next = tllp_pkg::S_CHK0;
                end
            end
            tllp_pkg::S_CHK0:
            begin
                if ((count_reg == '0) || !hit)
                begin
                    state_next = tllp_pkg::S_OUT;
                end
                else
                begin
                    state_next = tllp_pkg::S_ISSUE;
                end
            end
            tllp_pkg::S_ISSUE:
            begin
                state_next = search_go ? tllp_pkg::S_CMP : tllp_pkg::S_PREP;
            end
            tllp_pkg::S_CMP:
            begin
                state_next = tllp_pkg::S_ISSUE;
            end
            tllp_pkg::S_PREP:
            begin
                state_next = tllp_pkg::S_SAT;
            end
            tllp_pkg::S_SAT:
            begin
                state_next = (zero_reg || sat) ? tllp_pkg::S_OUT : tllp_pkg::S_DIV;
            end
            tllp_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = tllp_pkg::S_OUT;
                end
            end
            tllp_pkg::S_OUT:
            begin
                if (out_load)
                begin
                    state_next = tllp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tllp_pkg::S_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        mem_we    = 1'b0;
        rd_addr   = '0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            tllp_pkg::S_IDLE:
            begin
                cmd_ready = 1'b1;
                mem_we    = cmd_valid && !cmd.is_query && cmd.wr_en;
            end
            tllp_pkg::S_ISSUE:
            begin
                rd_addr = mid;
            end
            tllp_pkg::S_SAT:
            begin
                div_start = !zero_reg && !sat;
            end
            tllp_pkg::S_OUT:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    // line table, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lines_mem[AW'(cmd.slot)] <= '{start_ms: cmd.start_ms, stop_ms: cmd.stop_ms};
        end
        rd_data_reg <= lines_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tllp_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            last_idx_reg  <= tllp_pkg::IDX_NONE;
            last_prog_reg <= tllp_pkg::PROG_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                last_idx_reg  <= idx_now;
                last_prog_reg <= prog_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            tllp_pkg::S_IDLE:
            begin
                if (take_query)
                begin
                    pos_reg   <= cmd.pos_ms;
                    count_reg <= count_clamp;
                end
            end
            tllp_pkg::S_CHK0:
            begin
                lo_reg       <= '0;
                hi1_reg      <= count_reg;
                found_ok_reg <= 1'b0;
                prog_reg     <= tllp_pkg::PROG_ZERO;
            end
            tllp_pkg::S_CMP:
            begin
                if (hit)
                begin
                    found_reg    <= mid;
                    found_ok_reg <= 1'b1;
                    fstart_reg   <= rd_data_reg.start_ms;
                    fstop_reg    <= rd_data_reg.stop_ms;
                    lo_reg       <= mid_full + CW'(1);
                end
                else
                begin
                    hi1_reg <= mid_full;
                end
            end
            tllp_pkg::S_PREP:
            begin
                zero_reg <= !found_ok_reg || (fstop_reg <= fstart_reg) ||
                            (pos_reg <= fstart_reg);
                num_reg  <= pos_reg - fstart_reg;
                den_reg  <= fstop_reg - fstart_reg;
            end
            tllp_pkg::S_SAT:
            begin
                if (zero_reg)
                begin
                    prog_reg <= tllp_pkg::PROG_ZERO;
                end
                else if (sat)
                begin
                    prog_reg <= tllp_pkg::PROG_ONE;
                end
            end
            tllp_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    prog_reg <= {1'b0, div_quot};
                end
            end
            default:
            begin
                prog_reg <= prog_reg;
            end
        endcase
        if (out_load)
        begin
            out_res_reg.line_index       <= idx_now;
            out_res_reg.progress         <= prog_reg;
            out_res_reg.index_changed    <= (idx_now != last_idx_reg);
            out_res_reg.progress_changed <= (idx_now != last_idx_reg) ||
                                            (prog_reg != last_prog_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = out_res_reg;

endmodule

`default_nettype wire

// ===== sv/tllp_checker.sv =====
// port-level checker for the timed line locator, bound to the top level
`default_nettype none

`include "timed_line_locator_with_progress_macros.svh"

module tllp_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 out_valid,
    input wire logic                                 out_ready,
    input wire logic signed [tllp_pkg::IDX_W-1:0]    line_index,
    input wire logic [tllp_pkg::PROG_W-1:0]          progress,
    input wire logic                                 index_changed,
    input wire logic                                 progress_changed
);

    `TLLP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
    `TLLP_ASSERT_NOW(a_none_zero, out_valid && ($unsigned(line_index) == tllp_pkg::IDX_NONE), progress == tllp_pkg::PROG_ZERO, "progress set with no line")
    `TLLP_ASSERT_NOW(a_prog_max, out_valid, progress <= tllp_pkg::PROG_ONE, "progress above one")
    `TLLP_ASSERT_NOW(a_chg_imply, out_valid && index_changed, progress_changed, "index change without progress change")

endmodule

bind timed_line_locator_with_progress tllp_checker u_tllp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .line_index       (line_index),
    .progress         (progress),
    .index_changed    (index_changed),
    .progress_changed (progress_changed)
);

`default_nettype wire

// ===== tb/timed_line_locator_with_progress_tb.sv =====
// testbench for the timed line locator: directed and random beats checked by a built-in predictor
`timescale 1ns / 100ps

module timed_line_locator_with_progress_tb;

    localparam int TABLE_DEPTH  = 64;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic                               op_code;
        logic [tllp_pkg::SLOT_W-1:0]        slot;
        logic [tllp_pkg::TIME_W-1:0]        t_start;
        logic [tllp_pkg::TIME_W-1:0]        t_end;
        logic signed [tllp_pkg::TIME_W-1:0] pos;
    } beat_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [tllp_pkg::CNT_REG_W-1:0]     cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic                               op = tllp_pkg::OP_WRITE;
    logic [tllp_pkg::SLOT_W-1:0]        entry_index = '0;
    logic [tllp_pkg::TIME_W-1:0]        entry_start_ms = '0;
    logic [tllp_pkg::TIME_W-1:0]        entry_end_ms = '0;
    logic signed [tllp_pkg::TIME_W-1:0] position_ms = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [tllp_pkg::IDX_W-1:0]  line_index;
    logic [tllp_pkg::PROG_W-1:0]        progress;
    logic                               index_changed;
    logic                               progress_changed;

    // predictor state
    logic [tllp_pkg::TIME_W-1:0]        line_start [TABLE_DEPTH];
    logic [tllp_pkg::TIME_W-1:0]        line_end [TABLE_DEPTH];
    logic signed [tllp_pkg::IDX_W-1:0]  last_hit = tllp_pkg::IDX_NONE;
    logic [tllp_pkg::PROG_W-1:0]        last_frac = tllp_pkg::PROG_ZERO;
    logic [tllp_pkg::CNT_REG_W-1:0]     count_reg = '0;
    tllp_pkg::res_t                     results_due[$];

    // stimulus side
    beat_t                              pending[$];
    beat_t                              nxt;
    logic [tllp_pkg::TIME_W-1:0]        gen_start [TABLE_DEPTH];
    logic [tllp_pkg::TIME_W-1:0]        gen_end [TABLE_DEPTH];
    logic [tllp_pkg::TIME_W-1:0]        last_pos = '0;
    int                                 beats_queued = 0;
    int                                 beats_taken = 0;
    bit                                 in_taken = 1'b0;
    bit                                 calm = 1'b0;
    int                                 idle_left = 0;
    int                                 stall_left = 0;
    int                                 errors = 0;
    tllp_pkg::res_t                     want;

    timed_line_locator_with_progress #(.MAX_LINES(TABLE_DEPTH)) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .op               (op),
        .entry_index      (entry_index),
        .entry_start_ms   (entry_start_ms),
        .entry_end_ms     (entry_end_ms),
        .position_ms      (position_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .line_index       (line_index),
        .progress         (progress),
        .index_changed    (index_changed),
        .progress_changed (progress_changed)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic tllp_pkg::res_t locate_and_measure(
        input logic signed [tllp_pkg::TIME_W-1:0] pos_in);
        logic [tllp_pkg::TIME_W-1:0] pos;
        logic [tllp_pkg::TIME_W-1:0] delta;
        logic [tllp_pkg::TIME_W-1:0] width;
        logic [63:0]                 quo;
        logic [tllp_pkg::PROG_W-1:0] frac;
        int                          lo;
        int                          hi;
        int                          mid;
        int                          hit;
        int                          cnt;
        tllp_pkg::res_t              r;
        pos = pos_in[tllp_pkg::TIME_W-1] ? '0 : pos_in;
        cnt = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
        hit = -1;
        if (cnt != 0 && pos >= line_start[0])
        begin
            lo = 0;
            hi = cnt - 1;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (line_start[mid] <= pos)
                begin
                    hit = mid;
                    lo = mid + 1;
                end
                else
                    hi = mid - 1;
            end
        end
        frac = tllp_pkg::PROG_ZERO;
        if (hit >= 0 && line_end[hit] > line_start[hit] && pos > line_start[hit])
        begin
            delta = pos - line_start[hit];
            width = line_end[hit] - line_start[hit];
            quo = {16'd0, delta, 16'd0} / {32'd0, width};
            frac = (quo > tllp_pkg::PROG_ONE) ? tllp_pkg::PROG_ONE
                                              : quo[tllp_pkg::PROG_W-1:0];
        end
        r.line_index = tllp_pkg::IDX_W'(hit);
        r.progress = frac;
        r.index_changed = (r.line_index != last_hit);
        r.progress_changed = r.index_changed || (frac != last_frac);
        last_hit = r.line_index;
        last_frac = frac;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    // input beats: table writes update the predictor, queries queue a result
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            in_taken = 1'b1;
            beats_taken++;
            if (op == tllp_pkg::OP_WRITE)
            begin
                line_start[entry_index] = entry_start_ms;
                line_end[entry_index] = entry_end_ms;
            end
            else
                results_due.push_back(locate_and_measure(position_ms));
        end
    end

    always @(negedge clk)
    begin
        if (in_taken || !in_valid)
        begin
            if (!rst_n || idle_left > 0 || pending.size() == 0)
            begin
                in_valid <= 1'b0;
                if (idle_left > 0)
                    idle_left--;
            end
            else
            begin
                nxt = pending.pop_front();
                in_valid <= 1'b1;
                op <= nxt.op_code;
                entry_index <= nxt.slot;
                entry_start_ms <= nxt.t_start;
                entry_end_ms <= nxt.t_end;
                position_ms <= nxt.pos;
                idle_left = calm ? 0 : pick_gap();
            end
        end
        in_taken = 1'b0;
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, got index %0d progress %0d",
                         $time, line_index, progress);
                errors++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("line_index", want.line_index, line_index);
                check_field("progress", want.progress, progress);
                check_field("index_changed", want.index_changed, index_changed);
                check_field("progress_changed", want.progress_changed, progress_changed);
            end
        end
    end

    task automatic push_write(input int slot, input logic [tllp_pkg::TIME_W-1:0] s,
                              input logic [tllp_pkg::TIME_W-1:0] e);
        pending.push_back('{tllp_pkg::OP_WRITE, tllp_pkg::SLOT_W'(slot), s, e, '0});
        gen_start[slot] = s;
        gen_end[slot] = e;
        beats_queued++;
    endtask

    task automatic push_query(input logic [tllp_pkg::TIME_W-1:0] p);
        pending.push_back('{tllp_pkg::OP_QUERY, '0, '0, '0, p});
        last_pos = p;
        beats_queued++;
    endtask

    task automatic wait_idle();
        while (beats_taken != beats_queued || results_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_line_count(input logic [tllp_pkg::CNT_REG_W-1:0] v);
        wait_idle();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        count_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // sorted lines with random spacing, some empty, reversed or open-ended
    task automatic load_table(input int n);
        logic [tllp_pkg::TIME_W-1:0] t;
        logic [tllp_pkg::TIME_W-1:0] e;
        case ($urandom_range(0, 3))
            0: t = '0;
            1: t = $urandom_range(1, 20000);
            2: t = 32'h7FF0_0000 + $urandom_range(0, 65535);
            default: t = $urandom;
        endcase
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: e = t;
                1: e = t - $urandom_range(1, 500);
                2: e = 32'hFFFF_FFFF;
                default: e = t + $urandom_range(1, 4000);
            endcase
            push_write(i, t, e);
            if ($urandom_range(0, 7) != 0)
                t = t + $urandom_range(1, 4000);
        end
    endtask

    task automatic play_queries(input int n, input int eff);
        int                          r;
        int                          k;
        logic [tllp_pkg::TIME_W-1:0] span;
        logic [tllp_pkg::TIME_W-1:0] p;
        repeat (n)
        begin
            r = $urandom_range(0, 19);
            if (eff == 0 || r == 0)
                p = $urandom;
            else if (r == 1)
                p = last_pos;
            else if (r == 2)
                p = 32'd0 - $urandom_range(1, 5000);
            else if (r < 10)
                p = last_pos + $urandom_range(0, 400);
            else
            begin
                k = $urandom_range(0, eff - 1);
                if (gen_end[k] > gen_start[k] && gen_end[k] - gen_start[k] < 8000)
                    span = gen_end[k] - gen_start[k];
                else
                    span = 200;
                p = gen_start[k] + $urandom_range(0, span + 4) - 2;
            end
            push_query(p);
        end
    endtask

    initial
    begin
        int cnt;
        int eff;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table right after reset
        push_query(32'd0);
        push_query(32'hFFFF_FFFF);
        push_query(32'h8000_0000);
        push_query(32'h7FFF_FFFF);
        push_write(0, 32'd100, 32'd150);
        push_write(1, 32'd200, 32'd200);
        push_write(2, 32'd300, 32'd250);
        push_write(3, 32'h7FFF_FFF0, 32'hFFFF_FFFF);
        push_write(63, 32'hFFFF_FFFF, 32'd0);
        set_line_count(7'd4);
        push_query(32'd50);
        push_query(32'hFFFF_FFFB);
        push_query(32'd100);
        push_query(32'd125);
        push_query(32'd150);
        push_query(32'd199);
        push_query(32'd200);
        push_query(32'd250);
        push_query(32'd300);
        push_query(32'h7FFF_FFFF);
        push_query(32'h7FFF_FFFF);

        set_line_count(7'd64);
        load_table(TABLE_DEPTH);
        play_queries(40, TABLE_DEPTH);

        while (beats_queued < 620)
        begin
            case ($urandom_range(0, 9))
                0: cnt = 0;
                1: cnt = 1;
                2: cnt = 64;
                3: cnt = 127;
                4: cnt = $urandom_range(65, 126);
                default: cnt = $urandom_range(2, 16);
            endcase
            set_line_count(tllp_pkg::CNT_REG_W'(cnt));
            eff = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
            calm = ($urandom_range(0, 3) == 0);
            if (eff > 0 && $urandom_range(0, 1) == 1)
                load_table(eff);
            repeat ($urandom_range(0, 2))
                push_write($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom);
            play_queries($urandom_range(25, 50), eff);
        end

        wait_idle();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== timed_line_locator_with_progress.f =====
+incdir+sv
sv/tllp_pkg.sv
sv/tllp_front.sv
sv/tllp_div.sv
sv/tllp_back.sv
sv/timed_line_locator_with_progress.sv
sv/tllp_checker.sv
tb/timed_line_locator_with_progress_tb.sv
